>>> rtl/ctt_pkg.sv
// Shared types and constants for the CIA timer, TOD and port block.
// No dependencies; ctt_timer, ctt_tod and the top level refer to it by scoped names.
package ctt_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register map
    localparam logic [3:0] REG_PORT_A     = 4'd0;
    localparam logic [3:0] REG_DIR_A      = 4'd2;
    localparam logic [3:0] REG_TA_LO      = 4'd4;
    localparam logic [3:0] REG_TA_HI      = 4'd5;
    localparam logic [3:0] REG_TB_LO      = 4'd6;
    localparam logic [3:0] REG_TB_HI      = 4'd7;
    localparam logic [3:0] REG_TOD_TENTHS = 4'd8;
    localparam logic [3:0] REG_TOD_SEC    = 4'd9;
    localparam logic [3:0] REG_TOD_MIN    = 4'd10;
    localparam logic [3:0] REG_TOD_HR     = 4'd11;
    localparam logic [3:0] REG_ICR        = 4'd13;
    localparam logic [3:0] REG_CRA        = 4'd14;
    localparam logic [3:0] REG_CRB        = 4'd15;

    // Bit positions
    localparam int CR_START    = 0;
    localparam int CR_ONE_SHOT = 3;
    localparam int ICR_TA      = 0;
    localparam int ICR_TB      = 1;
    localparam int ICR_ANY     = 7;
    localparam int SERIAL_LSB  = 3;

    localparam int REG_COUNT = 16;

    // Decoded input item
    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       tod_pulse;
        logic       serial_clock_in;
        logic       serial_data_in;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] video_bank;
        logic       serial_update;
        logic       atn_out;
        logic       clock_out;
        logic       data_out;
        logic       nmi_pulse;
    } out_item_t;

    // Controls for one down-counter
    typedef struct packed {
        logic step;
        logic wr_lo;
        logic wr_hi;
        logic one_shot;
    } timer_ctl_t;

    // Controls for the time-of-day clock
    typedef struct packed {
        logic advance;
        logic wr_tenths;
        logic wr_sec;
        logic wr_min;
        logic wr_hr;
    } tod_ctl_t;

endpackage

>>> rtl/ctt_timer.sv
// One 16-bit down-counter with its reload latch.
// Depends on ctt_pkg for the control struct.
module ctt_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctt_pkg::timer_ctl_t   ctl,
    input  logic [7:0]            wdata,
    output logic [15:0]           count,
    output logic                  underflow
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] latch_reg;
    logic [15:0] latch_next;
    logic [15:0] dec;

    assign dec = count_reg - 16'd1;

    always_comb
    begin
        latch_next = latch_reg;
        count_next = count_reg;
        underflow  = 1'b0;
        if (ctl.wr_lo)
        begin
            latch_next = {latch_reg[15:8], wdata};
            count_next = latch_next;
        end
        else if (ctl.wr_hi)
        begin
            latch_next = {wdata, latch_reg[7:0]};
            count_next = latch_next;
        end
        else if (ctl.step)
        begin
            // a count of zero wraps to all ones with no underflow
            count_next = dec;
            if (dec == 16'd0)
            begin
                underflow = 1'b1;
                if (!ctl.one_shot)
                begin
                    count_next = latch_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            latch_reg <= 16'd0;
        end
        else
        begin
            count_reg <= count_next;
            latch_reg <= latch_next;
        end
    end

    assign count = count_reg;

endmodule

>>> rtl/ctt_tod.sv
// BCD time-of-day clock: digit registers, bus load and tenth-second advance.
// Depends on ctt_pkg for the control struct.
module ctt_tod (
    input  logic                clk,
    input  logic                rst_n,
    input  ctt_pkg::tod_ctl_t   ctl,
    input  logic [7:0]          wdata,
    output logic [7:0]          rd_tenths,
    output logic [7:0]          rd_sec,
    output logic [7:0]          rd_min,
    output logic [7:0]          rd_hr
);

    logic [3:0] tenths_reg, tenths_next;
    logic [3:0] sec_u_reg, sec_u_next;
    logic [2:0] sec_t_reg, sec_t_next;
    logic [3:0] min_u_reg, min_u_next;
    logic [2:0] min_t_reg, min_t_next;
    logic [3:0] hr_u_reg, hr_u_next;
    logic       hr_t_reg, hr_t_next;
    logic       pm_reg, pm_next;

    logic c_tenths, c_sec_u, c_sec_t, c_min_u, c_min_t;

    // carry only at the terminal value; other values just wrap in width
    assign c_tenths = (tenths_reg == 4'd9);
    assign c_sec_u  = c_tenths && (sec_u_reg == 4'd9);
    assign c_sec_t  = c_sec_u && (sec_t_reg == 3'd5);
    assign c_min_u  = c_sec_t && (min_u_reg == 4'd9);
    assign c_min_t  = c_min_u && (min_t_reg == 3'd5);

    always_comb
    begin
        tenths_next = tenths_reg;
        sec_u_next  = sec_u_reg;
        sec_t_next  = sec_t_reg;
        min_u_next  = min_u_reg;
        min_t_next  = min_t_reg;
        hr_u_next   = hr_u_reg;
        hr_t_next   = hr_t_reg;
        pm_next     = pm_reg;
        if (ctl.wr_tenths)
        begin
            tenths_next = wdata[3:0];
        end
        else if (ctl.wr_sec)
        begin
            sec_u_next = wdata[3:0];
            sec_t_next = wdata[6:4];
        end
        else if (ctl.wr_min)
        begin
            min_u_next = wdata[3:0];
            min_t_next = wdata[6:4];
        end
        else if (ctl.wr_hr)
        begin
            hr_u_next = wdata[3:0];
            hr_t_next = wdata[4];
            pm_next   = wdata[5];
        end
        else if (ctl.advance)
        begin
            tenths_next = c_tenths ? 4'd0 : tenths_reg + 4'd1;
            if (c_tenths)
            begin
                sec_u_next = (sec_u_reg == 4'd9) ? 4'd0 : sec_u_reg + 4'd1;
            end
            if (c_sec_u)
            begin
                sec_t_next = (sec_t_reg == 3'd5) ? 3'd0 : sec_t_reg + 3'd1;
            end
            if (c_sec_t)
            begin
                min_u_next = (min_u_reg == 4'd9) ? 4'd0 : min_u_reg + 4'd1;
            end
            if (c_min_u)
            begin
                min_t_next = (min_t_reg == 3'd5) ? 3'd0 : min_t_reg + 3'd1;
            end
            if (c_min_t)
            begin
                // 12 -> 01, 11 -> 12 with PM flip, x9 -> tens flip
                if (hr_t_reg && hr_u_reg == 4'd2)
                begin
                    hr_t_next = 1'b0;
                    hr_u_next = 4'd1;
                end
                else if (hr_t_reg && hr_u_reg == 4'd1)
                begin
                    hr_u_next = 4'd2;
                    pm_next   = ~pm_reg;
                end
                else if (hr_u_reg == 4'd9)
                begin
                    hr_u_next = 4'd0;
                    hr_t_next = ~hr_t_reg;
                end
                else
                begin
                    hr_u_next = hr_u_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tenths_reg <= 4'd0;
            sec_u_reg  <= 4'd0;
            sec_t_reg  <= 3'd0;
            min_u_reg  <= 4'd0;
            min_t_reg  <= 3'd0;
            hr_u_reg   <= 4'd0;
            hr_t_reg   <= 1'b0;
            pm_reg     <= 1'b0;
        end
        else
        begin
            tenths_reg <= tenths_next;
            sec_u_reg  <= sec_u_next;
            sec_t_reg  <= sec_t_next;
            min_u_reg  <= min_u_next;
            min_t_reg  <= min_t_next;
            hr_u_reg   <= hr_u_next;
            hr_t_reg   <= hr_t_next;
            pm_reg     <= pm_next;
        end
    end

    assign rd_tenths = {4'd0, tenths_reg};
    assign rd_sec    = {1'b0, sec_t_reg, sec_u_reg};
    assign rd_min    = {1'b0, min_t_reg, min_u_reg};
    assign rd_hr     = {2'b00, pm_reg, hr_t_reg, hr_u_reg};

endmodule

>>> rtl/cia_timer_tod_port_block.sv
// CIA-style block: sixteen byte registers, two down-counters, BCD TOD, port A.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle, sustained while m_tready stays high.
// Reset (rst_n, async, active low): registers, counters, latches, TOD and serial
// lines clear to zero, video bank to 3, both pipeline stages empty.
// Depends on ctt_pkg, ctt_timer and ctt_tod.
module cia_timer_tod_port_block (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: reg_addr[3:0], write_data[11:4], tod_pulse[12],
    // serial_clock_in[13], serial_data_in[14], zero pad[15]
    input  logic [15:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: read_data[7:0], video_bank[9:8], serial_update[10],
    // atn_out[11], clock_out[12], data_out[13], nmi_pulse[14], zero pad[15]
    output logic [15:0] m_tdata
);

    // ---------------------------------------------------------------
    // Pipeline control: the input register feeds the state update and
    // the result register; the input side keeps moving while a finished
    // result waits, as long as the result register is free or drained.
    // ---------------------------------------------------------------
    logic                in_valid_reg, in_valid_next;
    ctt_pkg::in_item_t   in_item_reg;
    logic                out_valid_reg, out_valid_next;
    ctt_pkg::out_item_t  out_item_reg, out_item_next;
    logic                advance;
    logic                fire;
    logic                load_in;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_item_reg.req_type        <= s_tuser;
            in_item_reg.reg_addr        <= s_tdata[3:0];
            in_item_reg.write_data      <= s_tdata[11:4];
            in_item_reg.tod_pulse       <= s_tdata[12];
            in_item_reg.serial_clock_in <= s_tdata[13];
            in_item_reg.serial_data_in  <= s_tdata[14];
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // ---------------------------------------------------------------
    // Decode of the item in the input register
    // ---------------------------------------------------------------
    logic       do_read, do_write, do_tick;
    logic [3:0] addr;
    logic [7:0] wdata;

    assign addr     = in_item_reg.reg_addr;
    assign wdata    = in_item_reg.write_data;
    assign do_read  = fire && (in_item_reg.req_type == ctt_pkg::REQ_READ);
    assign do_write = fire && (in_item_reg.req_type == ctt_pkg::REQ_WRITE);
    assign do_tick  = fire && (in_item_reg.req_type == ctt_pkg::REQ_TICK);

    // ---------------------------------------------------------------
    // Byte register file; only port A, direction A, ICR and the two
    // control registers are read at fixed places besides the bus read
    // ---------------------------------------------------------------
    logic [7:0] regs_reg  [ctt_pkg::REG_COUNT];
    logic [7:0] regs_next [ctt_pkg::REG_COUNT];
    logic [1:0] bank_reg, bank_next;
    logic [2:0] lines_reg, lines_next;

    logic [7:0] icr;
    logic [7:0] cra;
    logic [7:0] crb;

    assign icr = regs_reg[ctt_pkg::REG_ICR];
    assign cra = regs_reg[ctt_pkg::REG_CRA];
    assign crb = regs_reg[ctt_pkg::REG_CRB];

    // ---------------------------------------------------------------
    // Counters and TOD
    // ---------------------------------------------------------------
    ctt_pkg::timer_ctl_t ta_ctl, tb_ctl;
    ctt_pkg::tod_ctl_t   tod_ctl;
    logic [15:0] ta_count, tb_count;
    logic        ta_uf, tb_uf;
    logic [7:0]  tod_tenths, tod_sec, tod_min, tod_hr;

    assign ta_ctl.step     = do_tick && cra[ctt_pkg::CR_START];
    assign ta_ctl.wr_lo    = do_write && (addr == ctt_pkg::REG_TA_LO);
    assign ta_ctl.wr_hi    = do_write && (addr == ctt_pkg::REG_TA_HI);
    assign ta_ctl.one_shot = cra[ctt_pkg::CR_ONE_SHOT];

    assign tb_ctl.step     = do_tick && crb[ctt_pkg::CR_START];
    assign tb_ctl.wr_lo    = do_write && (addr == ctt_pkg::REG_TB_LO);
    assign tb_ctl.wr_hi    = do_write && (addr == ctt_pkg::REG_TB_HI);
    assign tb_ctl.one_shot = crb[ctt_pkg::CR_ONE_SHOT];

    assign tod_ctl.advance   = do_tick && in_item_reg.tod_pulse;
    assign tod_ctl.wr_tenths = do_write && (addr == ctt_pkg::REG_TOD_TENTHS);
    assign tod_ctl.wr_sec    = do_write && (addr == ctt_pkg::REG_TOD_SEC);
    assign tod_ctl.wr_min    = do_write && (addr == ctt_pkg::REG_TOD_MIN);
    assign tod_ctl.wr_hr     = do_write && (addr == ctt_pkg::REG_TOD_HR);

    ctt_timer u_timer_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ta_ctl),
        .wdata     (wdata),
        .count     (ta_count),
        .underflow (ta_uf)
    );

    ctt_timer u_timer_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tb_ctl),
        .wdata     (wdata),
        .count     (tb_count),
        .underflow (tb_uf)
    );

    ctt_tod u_tod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tod_ctl),
        .wdata     (wdata),
        .rd_tenths (tod_tenths),
        .rd_sec    (tod_sec),
        .rd_min    (tod_min),
        .rd_hr     (tod_hr)
    );

    // Underflow raises NMI only where its ICR enable is set
    logic nmi_a, nmi_b;
    assign nmi_a = ta_uf && icr[ctt_pkg::ICR_TA];
    assign nmi_b = tb_uf && icr[ctt_pkg::ICR_TB];

    // ---------------------------------------------------------------
    // State update: bus write, or tick side effects on ICR and controls
    // ---------------------------------------------------------------
    logic [7:0] pa_old;
    logic [7:0] dir_a;
    logic [7:0] pa_mix;

    assign pa_old = regs_reg[ctt_pkg::REG_PORT_A];
    assign dir_a  = regs_reg[ctt_pkg::REG_DIR_A];
    // output bits follow the new byte where driven, the old one elsewhere
    assign pa_mix = (wdata & dir_a) | (pa_old & ~dir_a);

    always_comb
    begin
        for (int i = 0; i < ctt_pkg::REG_COUNT; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        bank_next  = bank_reg;
        lines_next = lines_reg;
        if (do_write)
        begin
            regs_next[addr] = wdata;
            if (addr == ctt_pkg::REG_PORT_A)
            begin
                bank_next  = ~wdata[1:0];
                lines_next = pa_mix[ctt_pkg::SERIAL_LSB +: 3];
            end
        end
        else if (do_tick)
        begin
            if (nmi_a)
            begin
                regs_next[ctt_pkg::REG_ICR][ctt_pkg::ICR_TA]  = 1'b1;
                regs_next[ctt_pkg::REG_ICR][ctt_pkg::ICR_ANY] = 1'b1;
            end
            if (nmi_b)
            begin
                regs_next[ctt_pkg::REG_ICR][ctt_pkg::ICR_TB]  = 1'b1;
                regs_next[ctt_pkg::REG_ICR][ctt_pkg::ICR_ANY] = 1'b1;
            end
            // one-shot stops the counter by clearing its start bit
            if (ta_uf && cra[ctt_pkg::CR_ONE_SHOT])
            begin
                regs_next[ctt_pkg::REG_CRA][ctt_pkg::CR_START] = 1'b0;
            end
            if (tb_uf && crb[ctt_pkg::CR_ONE_SHOT])
            begin
                regs_next[ctt_pkg::REG_CRB][ctt_pkg::CR_START] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctt_pkg::REG_COUNT; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
            bank_reg  <= 2'd3;
            lines_reg <= 3'd0;
        end
        else
        begin
            for (int i = 0; i < ctt_pkg::REG_COUNT; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
            bank_reg  <= bank_next;
            lines_reg <= lines_next;
        end
    end

    // ---------------------------------------------------------------
    // Bus read mux
    // ---------------------------------------------------------------
    logic [7:0] rd_byte;

    always_comb
    begin
        case (addr)
            ctt_pkg::REG_PORT_A:
                rd_byte = {in_item_reg.serial_data_in, in_item_reg.serial_clock_in,
                           pa_old[5:0]};
            ctt_pkg::REG_TA_LO:      rd_byte = ta_count[7:0];
            ctt_pkg::REG_TA_HI:      rd_byte = ta_count[15:8];
            ctt_pkg::REG_TB_LO:      rd_byte = tb_count[7:0];
            ctt_pkg::REG_TB_HI:      rd_byte = tb_count[15:8];
            ctt_pkg::REG_TOD_TENTHS: rd_byte = tod_tenths;
            ctt_pkg::REG_TOD_SEC:    rd_byte = tod_sec;
            ctt_pkg::REG_TOD_MIN:    rd_byte = tod_min;
            ctt_pkg::REG_TOD_HR:     rd_byte = tod_hr;
            default:                 rd_byte = regs_reg[addr];
        endcase
    end

    // ---------------------------------------------------------------
    // Result item: bank and serial lines as they stand after the item
    // ---------------------------------------------------------------
    always_comb
    begin
        out_item_next.read_data     = do_read ? rd_byte : 8'd0;
        out_item_next.video_bank    = bank_next;
        out_item_next.serial_update = do_write && (addr == ctt_pkg::REG_PORT_A);
        out_item_next.atn_out       = lines_next[0];
        out_item_next.clock_out     = lines_next[1];
        out_item_next.data_out      = lines_next[2];
        out_item_next.nmi_pulse     = do_tick && (nmi_a || nmi_b);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_item_reg.nmi_pulse,
                       out_item_reg.data_out,
                       out_item_reg.clock_out,
                       out_item_reg.atn_out,
                       out_item_reg.serial_update,
                       out_item_reg.video_bank,
                       out_item_reg.read_data};

endmodule

>>> rtl/ctt_checker.sv
// Port-level checks for cia_timer_tod_port_block, bound to the top level.
// Depends only on the top level's port names.
module ctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // one item is a read, a write or a tick: its flags never mix
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[10] && m_tdata[14])
                  && !((m_tdata[7:0] != 8'd0) && (m_tdata[10] || m_tdata[14])))
        else $error("read data, port update and NMI in one item");

endmodule

bind cia_timer_tod_port_block ctt_checker u_ctt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
